@@ rtl/chmp_pkg.sv @@
// Shared types and constants for the cubic Hermite motion profile.
// No dependencies.
package chmp_pkg;

    typedef enum logic [1:0] {
        MODE_GET = 2'd0,
        MODE_SET = 2'd1,
        MODE_ADD = 2'd2,
        MODE_RSV = 2'd3
    } mode_t;

    localparam logic [31:0] DURATION_RESET = 32'd1000000000;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] lim_hi;
        logic signed [63:0] lim_lo;
        lim_hi = 64'sd2147483647;
        lim_lo = -64'sd2147483648;
        if (v > lim_hi) begin
            return 32'sh7fffffff;
        end else if (v < lim_lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

@@ rtl/cubic_hermite_motion_profile.sv @@
// Top level of the cubic Hermite motion profile.
// Depends on chmp_pkg and chmp_div.
//
// Usage: one item on the s_ channel is a request (get, set or add) with a
// timestamp; each request gives exactly one item on the m_ channel.
// s_axis_tuser: mode[1:0].
// s_axis_tdata (LSB up): now[TIME_BITS-1:0], amount[31:0], low_limit[31:0],
//   high_limit[31:0], zero padding to whole bytes.
// m_axis_tdata (LSB up): value[31:0], moving, zero padding.
// The user must write the duration register with cfg_wr_en / cfg_wr_data
// only while idle; the block itself does not enforce this. A set, and an add
// or get that needs no evaluation, goes from S_DECODE through S_OUT before
// its result is offered. A get or add that evaluates the segment runs the
// serial divider, then sequenced multiplies on one shared multiplier (S_COEF,
// S_M1 to S_M5, S_FIN), then S_OUT before the result is offered.
// One item is processed at a time; s_axis_tready is low while busy or while
// a result waits, and rises the cycle after the result is taken.
// A stalled receiver holds the result; nothing is lost.
// Reset puts the segment at rest at zero and duration at 1e9 ticks.
module cubic_hermite_motion_profile #(
    parameter int TIME_BITS = 48,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // mode
    // now, amount, low_limit, high_limit, padding
    input  logic [((TIME_BITS+96+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // value, moving, padding
);
    import chmp_pkg::*;

    localparam int NUM_W = TIME_BITS + FRAC_BITS;
    localparam int XB    = FRAC_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_DIV, S_COEF, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
        S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic [31:0]          duration_reg;
    logic                 active_reg;
    logic [TIME_BITS-1:0] start_time_reg;
    logic signed [31:0]   from_value_reg, from_slope_reg, to_value_reg;

    logic [1:0]           mode_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic signed [31:0]   amount_reg, lo_reg, hi_reg;
    logic signed [31:0]   nv_reg, res_reg;
    logic [XB-1:0]        x_reg;
    logic signed [63:0]   c_reg, d_reg, t_reg, u_reg, pos_reg;
    logic                 out_moving_reg;
    logic                 out_valid_reg;

    logic [TIME_BITS-1:0] elapsed;
    logic                 seg_done;
    logic signed [63:0]   cl_in_a, cl_in_t;
    logic signed [31:0]   clamp_a, clamp_t;
    logic                 div_start, div_done;
    logic [NUM_W-1:0]     div_q;

    // shared multiplier: round(mul_a * x / 2^FRAC_BITS), ties up
    logic signed [63:0]   mul_a, mul_p, mul_r;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v,
            input logic signed [31:0] lo, input logic signed [31:0] hi);
        logic signed [63:0] r;
        r = v;
        if (r < 64'(lo)) r = 64'(lo);
        if (r > 64'(hi)) r = 64'(hi);
        return r[31:0];
    endfunction

    assign elapsed  = now_reg - start_time_reg;
    assign seg_done = (64'(elapsed) >= 64'(duration_reg));
    assign cl_in_a  = 64'(from_value_reg) + 64'(amount_reg);
    assign cl_in_t  = 64'(to_value_reg) + 64'(amount_reg);
    assign clamp_a  = clamp32(cl_in_a, lo_reg, hi_reg);
    assign clamp_t  = clamp32(cl_in_t, lo_reg, hi_reg);
    assign mul_p    = mul_a * $signed({{(64-XB){1'b0}}, x_reg})
                      + (64'sd1 <<< (FRAC_BITS - 1));
    assign mul_r    = mul_p >>> FRAC_BITS;

    always_comb begin
        unique case (state_reg)
            S_M1:    mul_a = d_reg;
            S_M2:    mul_a = t_reg;
            S_M3:    mul_a = t_reg;
            S_M4:    mul_a = 3 * d_reg;
            S_M5:    mul_a = u_reg;
            default: mul_a = '0;
        endcase
    end

    assign div_start = (state_reg == S_DECODE) && active_reg && !seg_done
                       && (mode_reg == MODE_GET || mode_reg == MODE_RSV
                           || (mode_reg == MODE_ADD && clamp_t != to_value_reg));

    chmp_div #(.NUM_BITS(NUM_W), .DEN_BITS(32)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num({elapsed, {FRAC_BITS{1'b0}}}), .den(duration_reg),
        .done(div_done), .quot(div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            duration_reg   <= DURATION_RESET;
            active_reg     <= 1'b0;
            start_time_reg <= '0;
            from_value_reg <= '0;
            from_slope_reg <= '0;
            to_value_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                duration_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        mode_reg   <= s_axis_tuser;
                        now_reg    <= s_axis_tdata[TIME_BITS-1:0];
                        amount_reg <= s_axis_tdata[TIME_BITS+31:TIME_BITS];
                        lo_reg     <= s_axis_tdata[TIME_BITS+63:TIME_BITS+32];
                        hi_reg     <= s_axis_tdata[TIME_BITS+95:TIME_BITS+64];
                        state_reg  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    state_reg <= S_OUT;
                    if (mode_reg == MODE_SET) begin
                        res_reg        <= clamp32(64'(amount_reg), lo_reg, hi_reg);
                        from_value_reg <= clamp32(64'(amount_reg), lo_reg, hi_reg);
                        to_value_reg   <= clamp32(64'(amount_reg), lo_reg, hi_reg);
                        active_reg     <= 1'b0;
                    end else if (mode_reg == MODE_ADD) begin
                        if (!active_reg) begin
                            res_reg <= to_value_reg;
                            if (clamp_a != from_value_reg) begin
                                start_time_reg <= now_reg;
                                from_slope_reg <= '0;
                                to_value_reg   <= clamp_a;
                                active_reg     <= 1'b1;
                                res_reg        <= clamp_a;
                            end
                        end else begin
                            res_reg <= to_value_reg;
                            nv_reg  <= clamp_t;
                            if (clamp_t != to_value_reg) begin
                                res_reg <= clamp_t;
                                if (seg_done) begin
                                    start_time_reg <= now_reg;
                                    from_value_reg <= to_value_reg;
                                    from_slope_reg <= '0;
                                    to_value_reg   <= clamp_t;
                                end else begin
                                    state_reg <= S_DIV;
                                end
                            end
                        end
                    end else begin
                        if (!active_reg) begin
                            res_reg <= from_value_reg;
                        end else if (seg_done) begin
                            active_reg     <= 1'b0;
                            from_value_reg <= to_value_reg;
                            res_reg        <= to_value_reg;
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        x_reg     <= div_q[XB-1:0];
                        state_reg <= S_COEF;
                    end
                end
                S_COEF: begin
                    c_reg <= 3 * (64'(to_value_reg) - 64'(from_value_reg))
                             - 2 * 64'(from_slope_reg);
                    d_reg <= 2 * (64'(from_value_reg) - 64'(to_value_reg))
                             + 64'(from_slope_reg);
                    state_reg <= S_M1;
                end
                S_M1: begin
                    t_reg     <= c_reg + mul_r;
                    state_reg <= S_M2;
                end
                S_M2: begin
                    t_reg     <= 64'(from_slope_reg) + mul_r;
                    state_reg <= S_M3;
                end
                S_M3: begin
                    pos_reg   <= 64'(from_value_reg) + mul_r;
                    state_reg <= S_M4;
                end
                S_M4: begin
                    u_reg     <= 2 * c_reg + mul_r;
                    state_reg <= S_M5;
                end
                S_M5: begin
                    u_reg     <= 64'(from_slope_reg) + mul_r;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    state_reg <= S_OUT;
                    if (mode_reg == MODE_ADD) begin
                        start_time_reg <= now_reg;
                        from_value_reg <= sat32(pos_reg);
                        from_slope_reg <= sat32(u_reg);
                        to_value_reg   <= nv_reg;
                        res_reg        <= nv_reg;
                    end else begin
                        res_reg <= sat32(pos_reg);
                    end
                end
                S_OUT: begin
                    out_moving_reg <= active_reg;
                    out_valid_reg  <= 1'b1;
                    state_reg      <= S_M6;
                end
                S_M6: begin
                    if (m_axis_tready) begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_moving_reg, res_reg};

    logic unused_in;
    assign unused_in = ^(s_axis_tdata >> (TIME_BITS + 96));
endmodule

@@ rtl/chmp_div.sv @@
// Restoring divider, one quotient bit per cycle: q = floor(num / den).
// Depends on nothing else.
module chmp_div #(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quot_reg, quot_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;

    always_comb begin
        trial     = {rem_reg[DEN_BITS-1:0], quot_reg[NUM_BITS-1]};
        quot_next = {quot_reg[NUM_BITS-2:0], 1'b0};
        rem_next  = trial;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quot_next = num;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next     = trial - {1'b0, den_reg};
                quot_next[0] = 1'b1;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else begin
            quot_next = quot_reg;
            rem_next  = rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

@@ rtl/chmp_checker.sv @@
// Port-level checks for the cubic Hermite motion profile.
// Bound onto cubic_hermite_motion_profile.
module chmp_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result waits");

    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid && !s_axis_tready)
        else $error("item accepted with no processing");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
        else $error("padding not zero");
endmodule

bind cubic_hermite_motion_profile chmp_checker u_chmp_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
